// ===== hdl/pshm_pkg.sv =====
`timescale 1ns / 1ps

package pshm_pkg;

  // Width of the modulus, base and hash values.
  localparam int MOD_WIDTH = 40;
  localparam int CHAR_WIDTH = 8;
  localparam int CNT_WIDTH = $clog2(MOD_WIDTH);

  // Configuration register indexes.
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_BASE    = 1'b1;

  localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(1);
  localparam logic [MOD_WIDTH-1:0] BASE_RESET    = MOD_WIDTH'(257);

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] char_code;
    logic                  last_char;
  } char_item_t;

  typedef struct packed {
    logic [MOD_WIDTH-1:0] hash_value;
    logic                 hash_final;
  } hash_item_t;

  // Operands of one modular step: ((dbl ? 2*acc : acc) + addend) mod m.
  typedef struct packed {
    logic                 dbl;
    logic [MOD_WIDTH-1:0] acc;
    logic [MOD_WIDTH-1:0] addend;
  } step_req_t;

endpackage

// ===== hdl/pshm_modstep.sv =====
`timescale 1ns / 1ps

// One modular step. Operands must satisfy result-before-reduce < 3*m.
module pshm_modstep (
  input  pshm_pkg::step_req_t             req,
  input  logic [pshm_pkg::MOD_WIDTH-1:0]  m,
  output logic [pshm_pkg::MOD_WIDTH-1:0]  result
);
  import pshm_pkg::*;

  localparam int XW = MOD_WIDTH + 2;

  logic [XW-1:0] x;
  logic [XW-1:0] m1;
  logic [XW-1:0] m2;
  logic [XW-1:0] d1;
  logic [XW-1:0] d2;

  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (req.dbl) begin
      x = {1'b0, req.acc, 1'b0} + {2'b00, req.addend};
    end else begin
      x = {2'b00, req.acc} + {2'b00, req.addend};
    end
    d1 = x - m1;
    d2 = x - m2;
    if (x >= m2) begin
      result = d2[MOD_WIDTH-1:0];
    end else if (x >= m1) begin
      result = d1[MOD_WIDTH-1:0];
    end else begin
      result = x[MOD_WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/polynomial_string_hash_mod.sv =====
`timescale 1ns / 1ps

// Polynomial rolling string hash: hash = (hash * base + char_code) mod modulus.
//
// Channels (valid/ready, a transfer when both are high at a clock edge):
//   char_*  one character per transfer; last_char closes the string.
//   res_*   one result per character: the running hash, hash_final set on
//           the last character of a string.
//   cfg_*   register writes: index 0 modulus, index 1 base. Always ready;
//           write only while the block is idle. A modulus of zero acts as one.
// The product is formed by a shift-and-add over all hash bits, one bit per
// cycle through a single compare-subtract unit; the character code is then
// added in a final step that hands off the result.
// The first character after any register write first reduces the base by
// the modulus; a modulus below 256 also reduces the character code before
// the final step. One character is in flight at a time.
// The finished result sits in an output register, so the next character is
// taken while it waits; if the receiver stalls, the following result holds
// in the final step until the register frees up.
// Reset: modulus 1, base 257, running hash 0, no result pending.
module polynomial_string_hash_mod (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           char_valid,
  output logic                           char_ready,
  input  pshm_pkg::char_item_t           char_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output pshm_pkg::hash_item_t           res_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [pshm_pkg::MOD_WIDTH-1:0] cfg_data
);
  import pshm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_REDB = 5'b00010,  // reduce base by modulus
    ST_MUL  = 5'b00100,  // double-and-add, hash MSB first
    ST_REDC = 5'b01000,  // reduce char code (small modulus only)
    ST_ADD  = 5'b10000   // add char, hand off result
  } state_t;

  localparam logic [CNT_WIDTH-1:0] CNT_TOP  = CNT_WIDTH'(MOD_WIDTH - 1);
  localparam logic [CNT_WIDTH-1:0] CNT_CHAR = CNT_WIDTH'(CHAR_WIDTH - 1);

  state_t                state;
  logic [MOD_WIDTH-1:0]  modulus;
  logic [MOD_WIDTH-1:0]  base;
  logic [MOD_WIDTH-1:0]  bred;       // base mod modulus
  logic                  bred_valid;
  logic [MOD_WIDTH-1:0]  hash;       // running hash
  logic [MOD_WIDTH-1:0]  acc;
  logic [CHAR_WIDTH-1:0] cred;       // char code mod modulus
  logic [CNT_WIDTH-1:0]  cnt;
  logic [CHAR_WIDTH-1:0] ch;
  logic                  last;

  logic [MOD_WIDTH-1:0]  m_eff;
  logic                  small_m;
  step_req_t             req;
  logic [MOD_WIDTH-1:0]  step_res;
  logic                  char_xfer;
  logic                  add_fire;

  assign m_eff   = (modulus == '0) ? MOD_WIDTH'(1) : modulus;
  assign small_m = (m_eff[MOD_WIDTH-1:CHAR_WIDTH] == '0);

  assign char_ready = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign char_xfer  = char_valid && char_ready;
  assign add_fire   = (state == ST_ADD) && (!res_valid || res_ready);

  // Feed the shared unit according to the current step.
  always_comb begin
    req.dbl    = 1'b1;
    req.acc    = acc;
    req.addend = '0;
    case (state)
      ST_REDB: begin
        req.addend = MOD_WIDTH'(base[cnt]);
      end
      ST_MUL: begin
        req.addend = hash[cnt] ? bred : '0;
      end
      ST_REDC: begin
        req.acc    = MOD_WIDTH'(cred);
        req.addend = MOD_WIDTH'(ch[cnt[$clog2(CHAR_WIDTH)-1:0]]);
      end
      ST_ADD: begin
        req.dbl    = 1'b0;
        req.addend = small_m ? MOD_WIDTH'(cred) : MOD_WIDTH'(ch);
      end
      default: begin
        req.dbl = 1'b1;
      end
    endcase
  end

  pshm_modstep u_step (
    .req    (req),
    .m      (m_eff),
    .result (step_res)
  );

  // Configuration; any write invalidates the cached reduced base.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= MODULUS_RESET;
      base       <= BASE_RESET;
      bred_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bred_valid <= 1'b0;
        if (cfg_index == REG_MODULUS) begin
          modulus <= cfg_data;
        end else begin
          base <= cfg_data;
        end
      end else if (state == ST_REDB && cnt == '0) begin
        bred_valid <= 1'b1;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hash      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (char_xfer) begin
            state <= bred_valid ? ST_MUL : ST_REDB;
          end
        end
        ST_REDB: begin
          if (cnt == '0) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt == '0) begin
            state <= small_m ? ST_REDC : ST_ADD;
          end
        end
        ST_REDC: begin
          if (cnt == '0) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (add_fire) begin
            res_valid <= 1'b1;
            hash      <= last ? '0 : step_res;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (char_xfer) begin
          ch   <= char_data.char_code;
          last <= char_data.last_char;
          acc  <= '0;
          cnt  <= CNT_TOP;
        end
      end
      ST_REDB: begin
        if (cnt == '0) begin
          bred <= step_res;
          acc  <= '0;
          cnt  <= CNT_TOP;
        end else begin
          acc <= step_res;
          cnt <= cnt - 1'b1;
        end
      end
      ST_MUL: begin
        acc <= step_res;
        if (cnt == '0) begin
          cred <= '0;
          cnt  <= CNT_CHAR;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      ST_REDC: begin
        cred <= step_res[CHAR_WIDTH-1:0];
        cnt  <= cnt - 1'b1;
      end
      ST_ADD: begin
        if (add_fire) begin
          res_data.hash_value <= step_res;
          res_data.hash_final <= last;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // A new result only comes out of the final step.
  a_res_from_add: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_ADD))
    else $error("result appeared outside the final step");

  // The multiply leaves only toward the char reduction or the final step.
  a_mul_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> (state == ST_MUL || state == ST_REDC || state == ST_ADD))
    else $error("bad exit from multiply");

  // The last character of a string clears the running hash.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (add_fire && last) |=> (hash == '0))
    else $error("running hash not cleared after last character");

endmodule

// ===== tb/sv/polynomial_string_hash_mod_tb.sv =====
`timescale 1ns / 1ps

module polynomial_string_hash_mod_tb;
  import pshm_pkg::*;

  // Clock period is 10 ns; the watchdog is far above the slowest correct run
  // (about 1300 characters, plus stalls).
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES_PER_MODE = 6;
  localparam int CHARS_PER_PHASE = 56;

  // Largest prime below 2^40, and the all-ones value of a register.
  localparam logic [MOD_WIDTH-1:0] PRIME_40 = MOD_WIDTH'(64'd1099511627689);
  localparam logic [MOD_WIDTH-1:0] ALL_ONES = '1;

  // Tracks the running hash and the register copy, and holds the hashes
  // still owed by the block in transfer order.
  class hash_scoreboard;
    logic [MOD_WIDTH-1:0] modulus = MODULUS_RESET;
    logic [MOD_WIDTH-1:0] base = BASE_RESET;
    logic [MOD_WIDTH-1:0] running_hash = '0;
    hash_item_t pending_hashes[$];
    int errors = 0;
    int checked = 0;

    function void write_reg(logic idx, logic [MOD_WIDTH-1:0] val);
      if (idx == REG_MODULUS) modulus = val;
      else base = val;
    endfunction

    // (running_hash * base + ch) mod modulus, by double-and-add so no bit
    // of the product is lost; a zero modulus acts as one.
    function logic [MOD_WIDTH-1:0] fold_char(logic [CHAR_WIDTH-1:0] ch);
      logic [63:0] m;
      logic [63:0] h;
      logic [63:0] b;
      logic [63:0] acc;
      m = (modulus == '0) ? 64'd1 : 64'(modulus);
      h = 64'(running_hash) % m;
      b = 64'(base) % m;
      acc = '0;
      for (int i = MOD_WIDTH - 1; i >= 0; i--) begin
        acc = (acc << 1) % m;
        if (h[i]) acc = (acc + b) % m;
      end
      acc = (acc + 64'(ch)) % m;
      return acc[MOD_WIDTH-1:0];
    endfunction

    function void note_char(char_item_t item);
      hash_item_t want;
      want.hash_value = fold_char(item.char_code);
      want.hash_final = item.last_char;
      pending_hashes.push_back(want);
      running_hash = item.last_char ? '0 : want.hash_value;
    endfunction

    function void check_hash(hash_item_t got);
      hash_item_t want;
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected result, nothing pending: got hash %h final %b",
                 $time, got.hash_value, got.hash_final);
        errors++;
      end else begin
        want = pending_hashes.pop_front();
        checked++;
        if (got.hash_value !== want.hash_value) begin
          $display("%0t: hash_value mismatch: expected %h, actual %h",
                   $time, want.hash_value, got.hash_value);
          errors++;
        end
        if (got.hash_final !== want.hash_final) begin
          $display("%0t: hash_final mismatch: expected %b, actual %b",
                   $time, want.hash_final, got.hash_final);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic char_valid = 1'b0;
  logic char_ready;
  char_item_t char_data = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  hash_item_t res_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_MODULUS;
  logic [MOD_WIDTH-1:0] cfg_data = '0;

  hash_scoreboard board = new;

  // Idle odds in percent per cycle for each side.
  int send_idle = 37;
  int recv_idle = 75;

  int chars_sent = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  polynomial_string_hash_mod dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_data (char_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: values read right after the edge are the ones the edge saw,
  // since every driver here and in the block updates through the NBA region.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) board.check_hash(res_data);
    res_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d hashes still pending",
               $time, cycle_count, board.pending_hashes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [MOD_WIDTH-1:0] rand_word();
    return MOD_WIDTH'({$urandom, $urandom});
  endfunction

  // Byte codes lean toward the two extremes now and then.
  function automatic logic [CHAR_WIDTH-1:0] rand_char();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return CHAR_WIDTH'($urandom_range(255));
    endcase
  endfunction

  // One character transfer. Random idle cycles go in front of it; valid then
  // holds with fixed data until the block takes it.
  task automatic send_char(input logic [CHAR_WIDTH-1:0] code, input logic last);
    char_item_t item;
    item.char_code = code;
    item.last_char = last;
    while ($urandom_range(99) < send_idle) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data <= item;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    board.note_char(item);
    chars_sent++;
  endtask

  // A string of random bytes; close marks its final byte as last.
  task automatic send_string(input int len, input bit close);
    for (int i = 0; i < len; i++) send_char(rand_char(), close && (i == len - 1));
  endtask

  // Stop sending and wait until every owed hash has come back. Every
  // character yields a result, so the block is idle once the queue drains.
  task automatic drain_hashes();
    char_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_hashes.size() != 0) @(posedge clk);
  endtask

  // Hold valid across back-to-back writes; it drops once at the end.
  task automatic cfg_transfer(input logic idx, input logic [MOD_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic set_regs(input bit wr_mod, input logic [MOD_WIDTH-1:0] mod_val,
                          input bit wr_base, input logic [MOD_WIDTH-1:0] base_val);
    if (wr_mod) cfg_transfer(REG_MODULUS, mod_val);
    if (wr_base) cfg_transfer(REG_BASE, base_val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int which;
    int count;
    int len;
    int pick;
    logic [MOD_WIDTH-1:0] mod_val;
    logic [MOD_WIDTH-1:0] base_val;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part ----
    // Reset registers: modulus 1, so every hash is zero.
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    drain_hashes();

    // Largest 40-bit prime with an all-ones base: base at or above modulus
    // must be reduced first. String left open so the hash stays large.
    set_regs(1'b1, PRIME_40, 1'b1, ALL_ONES);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h01, 1'b0);
    drain_hashes();

    // Modulus shrinks mid-string to a value below 256: the carried hash and
    // the byte FF exceed it, and the byte FB equals it.
    set_regs(1'b1, MOD_WIDTH'(251), 1'b0, '0);
    send_char(8'hFF, 1'b0);
    send_char(8'hFB, 1'b0);
    send_char(8'hFA, 1'b1);
    drain_hashes();

    // Zero modulus acts as one.
    set_regs(1'b1, '0, 1'b0, '0);
    send_char(8'hC3, 1'b0);
    send_char(8'h3C, 1'b1);
    drain_hashes();

    // All-ones modulus with zero base: the hash is just the last byte.
    set_regs(1'b1, ALL_ONES, 1'b1, '0);
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b0);
    send_char(8'h00, 1'b1);
    drain_hashes();

    // Usual setup, single-character strings.
    set_regs(1'b1, MOD_WIDTH'(1000000007), 1'b1, MOD_WIDTH'(257));
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'h41, 1'b1);

    // ---- Random part: three idle patterns, several register settings each ----
    for (int mode = 0; mode < 3; mode++) begin
      drain_hashes();
      case (mode)
        0: begin
          send_idle = 37;
          recv_idle = 75;
        end
        1: begin
          send_idle = 75;
          recv_idle = 37;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase

      for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
        drain_hashes();
        case ($urandom_range(7))
          0: mod_val = MOD_WIDTH'(1);
          1: mod_val = '0;
          2: mod_val = ALL_ONES;
          3: mod_val = PRIME_40;
          4: mod_val = MOD_WIDTH'($urandom_range(255, 2));
          5: mod_val = MOD_WIDTH'(1000000007);
          default: mod_val = rand_word();
        endcase
        case ($urandom_range(6))
          0: base_val = '0;
          1: base_val = ALL_ONES;
          2: base_val = MOD_WIDTH'(257);
          3: base_val = MOD_WIDTH'(31);
          default: base_val = rand_word();
        endcase
        // Both registers, or only one of them, so settings mix across phases.
        which = $urandom_range(2);
        set_regs(which != 2, mod_val, which != 1, base_val);

        count = 0;
        while (count < CHARS_PER_PHASE) begin
          pick = $urandom_range(99);
          if (pick < 10) len = 1;
          else if (pick < 92) len = $urandom_range(24, 2);
          else len = $urandom_range(80, 40);
          send_string(len, 1'b1);
          count += len;
        end
        // Sometimes leave a string open across the next register change.
        if ($urandom_range(2) == 0) send_string($urandom_range(8, 1), 1'b0);
      end
    end

    drain_hashes();
    // Nothing should show up after the last owed hash.
    repeat (3 * MOD_WIDTH) @(posedge clk);

    $display("Sent %0d characters through %0d register writes under three idle patterns;",
             chars_sent, cfg_writes);
    $display("checked %0d hashes, %0d mismatches or stray results.",
             board.checked, board.errors);
    if (board.errors == 0 && board.pending_hashes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
